### hw/rtl/slhb_pkg.sv
// Package for the slew-limited H-bridge drive: state codes, register
// indexes, field widths and reset values of the configuration registers.
// No dependencies.
`default_nettype none

package slhb_pkg;

    localparam int DUTY_BITS_DEF = 8;
    localparam int MV_W          = 16;
    localparam int CFG_W         = 15;
    localparam int CFG_ADDR_W    = 8;
    localparam int OUT_W         = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SLEW_UP   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLEW_DOWN = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_OUT   = 8'd3;

    localparam logic [CFG_W-1:0] SLEW_UP_RST   = 15'd800;
    localparam logic [CFG_W-1:0] SLEW_DOWN_RST = 15'd800;
    localparam logic [CFG_W-1:0] DEADBAND_RST  = 15'd2100;
    localparam logic [CFG_W-1:0] MAX_OUT_RST   = 15'd12000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLEW,
        ST_CLAMP,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/slhb_div.sv
// Restoring serial divider for the duty: round(maxd * mag / supply), one
// quotient bit per cycle. Depends on slhb_pkg for field widths.
`default_nettype none

module slhb_div #(
    parameter int DUTY_BITS = slhb_pkg::DUTY_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [slhb_pkg::CFG_W-1:0]    mag,
    input  wire logic [slhb_pkg::MV_W-1:0]     supply,
    output logic                               done,
    output logic [DUTY_BITS-1:0]               quot
);

    localparam int NW = DUTY_BITS + 17;
    localparam int CW = $clog2(DUTY_BITS + 1);

    logic [NW-1:0]        mag_w;
    logic [NW-1:0]        prod;
    logic [NW-1:0]        num;
    logic [17:0]          rem_reg, rem_next;
    logic [DUTY_BITS-1:0] low_reg, low_next;
    logic [16:0]          den_reg, den_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [17:0]          trial;
    logic [17:0]          diff;
    logic                 fits;

    always_comb begin
        mag_w = NW'(mag);
        prod  = (mag_w << DUTY_BITS) - mag_w;
        num   = (prod << 1) + NW'(supply);
        trial = {rem_reg[16:0], low_reg[DUTY_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};

        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = 18'(num[NW-1:DUTY_BITS]);
            low_next  = num[DUTY_BITS-1:0];
            den_next  = {supply, 1'b0};
            cnt_next  = CW'(DUTY_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff : trial;
            low_next = {low_reg[DUTY_BITS-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

`default_nettype wire

### hw/rtl/slew_limited_hbridge_drive_top.sv
// Top level of the slew-limited H-bridge drive: sequencer, slew and clamp
// steps, output register. Depends on slhb_pkg and slhb_div.
//
//   channel   dir  handshake            payload
//   s_        in   s_tvalid/s_tready    tdata: target_mv, supply_mv
//   m_        out  m_tvalid/m_tready    tdata: duty, level_a, level_b, applied_mv
//                                       tuser: write_strobe
//   cfg_      in   cfg_we               cfg_addr, cfg_wdata
//
// A transfer passes from accept through the slew, clamp, load and divide steps to
// the done step; the serial divider in the divide step makes one duty bit per cycle.
// A zero magnitude skips the load and divide steps.
// Reset is synchronous; the configuration registers return to their package defaults.
// A stalled result holds in the output register; the block accepts no new
// transfer until the pending result has left the sequencer.
`default_nettype none

module slew_limited_hbridge_drive_top #(
    parameter int DUTY_BITS = slhb_pkg::DUTY_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [31:0]                        s_tdata,   // target_mv, supply_mv
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [39:0]                             m_tdata,   // duty, level_a, level_b, applied_mv
    output logic                                    m_tuser,   // write_strobe
    input  wire logic                               cfg_we,
    input  wire logic [slhb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [slhb_pkg::CFG_W-1:0]         cfg_wdata
);

    slhb_pkg::state_t state_reg, state_next;

    logic [slhb_pkg::CFG_W-1:0] slew_up_reg, slew_down_reg, deadband_reg, max_out_reg;
    logic signed [15:0]         cur_reg, cur_next;
    logic signed [15:0]         val_reg, val_next;
    logic [15:0]                supply_reg, supply_next;
    logic [14:0]                mag_reg, mag_next;
    logic                       m_valid_reg, m_valid_next;
    logic [39:0]                m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;

    logic                       div_start;
    logic                       div_done;
    logic [DUTY_BITS-1:0]       div_quot;
    logic [DUTY_BITS+7:0]       quot_x;
    logic [7:0]                 duty8;
    logic                       strobe;

    logic signed [17:0] t18, c18, lim18, mag18, up18, dn18, db18, v18, cap18;

    slhb_div #(
        .DUTY_BITS (DUTY_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (mag_reg),
        .supply  (supply_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slew_up_reg   <= slhb_pkg::SLEW_UP_RST;
            slew_down_reg <= slhb_pkg::SLEW_DOWN_RST;
            deadband_reg  <= slhb_pkg::DEADBAND_RST;
            max_out_reg   <= slhb_pkg::MAX_OUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                slhb_pkg::REG_SLEW_UP:   slew_up_reg   <= cfg_wdata;
                slhb_pkg::REG_SLEW_DOWN: slew_down_reg <= cfg_wdata;
                slhb_pkg::REG_DEADBAND:  deadband_reg  <= cfg_wdata;
                slhb_pkg::REG_MAX_OUT:   max_out_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        quot_x = {8'd0, div_quot};
        duty8  = (mag_reg == 15'd0) ? 8'd0 : quot_x[7:0];
        strobe = val_reg != cur_reg;

        up18 = signed'({3'b000, slew_up_reg});
        dn18 = signed'({3'b000, slew_down_reg});
        db18 = signed'({3'b000, deadband_reg});
        t18  = 18'(val_reg);
        c18  = 18'(cur_reg);
        mag18 = (t18 < 0) ? -t18 : t18;
        lim18 = '0;
        if (t18 != c18) begin
            if (mag18 < db18) begin
                t18 = '0;
            end
            if (c18 > 0) begin
                if (t18 > c18) begin
                    lim18 = c18 + up18;
                    if (t18 > lim18) t18 = lim18;
                end else if (t18 < c18) begin
                    lim18 = c18 - dn18;
                    if (t18 < lim18) t18 = lim18;
                end
            end else begin
                if (t18 > c18) begin
                    lim18 = c18 + dn18;
                    if (t18 > lim18) t18 = lim18;
                end else if (t18 < c18) begin
                    lim18 = c18 - up18;
                    if (t18 < lim18) t18 = lim18;
                end
            end
        end

        cap18 = ({1'b0, max_out_reg} < {1'b0, supply_reg[14:0]} || supply_reg[15] == 1'b1)
                ? signed'({3'b000, max_out_reg}) : signed'({2'b00, supply_reg});
        v18 = 18'(val_reg);
        if (v18 > cap18) begin
            v18 = cap18;
        end else if (v18 < -cap18) begin
            v18 = -cap18;
        end

        state_next   = state_reg;
        cur_next     = cur_reg;
        val_next     = val_reg;
        supply_next  = supply_reg;
        mag_next     = mag_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        div_start    = 1'b0;
        s_tready     = 1'b0;

        unique case (state_reg)
            slhb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    val_next    = signed'(s_tdata[15:0]);
                    supply_next = s_tdata[31:16];
                    state_next  = slhb_pkg::ST_SLEW;
                end
            end
            slhb_pkg::ST_SLEW: begin
                val_next   = t18[15:0];
                state_next = slhb_pkg::ST_CLAMP;
            end
            slhb_pkg::ST_CLAMP: begin
                val_next   = v18[15:0];
                mag_next   = (v18 < 0) ? 15'(-v18) : 15'(v18);
                state_next = (v18 == 0) ? slhb_pkg::ST_DONE : slhb_pkg::ST_LOAD;
            end
            slhb_pkg::ST_LOAD: begin
                div_start  = 1'b1;
                state_next = slhb_pkg::ST_DIV;
            end
            slhb_pkg::ST_DIV: begin
                if (div_done) state_next = slhb_pkg::ST_DONE;
            end
            slhb_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = strobe;
                    m_data_next  = {(strobe ? val_reg : cur_reg),
                                    ((strobe && val_reg > 0) ? duty8 : 8'd0),
                                    ((strobe && val_reg < 0) ? duty8 : 8'd0),
                                    duty8};
                    if (strobe) cur_next = val_reg;
                    state_next = slhb_pkg::ST_IDLE;
                end
            end
            default: state_next = slhb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slhb_pkg::ST_IDLE;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
        val_reg    <= val_next;
        supply_reg <= supply_next;
        mag_reg    <= mag_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_quiet_legs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23:8] == 16'd0)
        else $error("legs driven without write strobe");

    a_one_leg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:8] == 8'd0 || m_tdata[23:16] == 8'd0)
        else $error("both legs driven");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a transfer while working");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == slhb_pkg::ST_DIV)
        else $error("divider finished outside divide step");

    a_applied_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:24] != 16'h8000)
        else $error("applied voltage out of range");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for slew_limited_hbridge_drive_top: random bursty stream
// traffic against an in-bench slew, clamp and duty predictor, several register settings.
// Depends on slhb_pkg and the RTL of the drive block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_W = slhb_pkg::DUTY_BITS_DEF;
    localparam longint unsigned FULL_SCALE = (64'd1 << DUTY_W) - 1;
    localparam int DRAIN_CYCLES = 3 * (DUTY_W + 6);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int CFG_MAX = 32767;

    typedef struct packed {
        logic [15:0] supply_mv;
        logic [15:0] target_mv;
    } drive_cmd_t;

    typedef struct packed {
        logic [15:0] applied_mv;
        logic [7:0]  level_b;
        logic [7:0]  level_a;
        logic [7:0]  duty;
    } drive_levels_t;

    typedef struct packed {
        logic          strobe;
        drive_levels_t levels;
    } drive_update_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [39:0]                     m_tdata;
    logic                            m_tuser;
    logic                            cfg_we = 1'b0;
    logic [slhb_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [slhb_pkg::CFG_W-1:0]      cfg_wdata = '0;

    slew_limited_hbridge_drive_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    drive_cmd_t    pending_cmds[$];
    drive_update_t expected_updates[$];

    logic [slhb_pkg::CFG_W-1:0] slew_up_cfg;
    logic [slhb_pkg::CFG_W-1:0] slew_down_cfg;
    logic [slhb_pkg::CFG_W-1:0] deadband_cfg;
    logic [slhb_pkg::CFG_W-1:0] max_out_cfg;
    int                         applied_now;

    int err_count = 0;
    int n_updates = 0;
    int n_strobes = 0;
    int n_settings = 1;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] duty_for(int unsigned mag, int unsigned supply);
        longint unsigned num;
        if (supply == 0) return 8'd0;
        num = 2 * FULL_SCALE * mag + supply;
        return 8'(num / (2 * longint'(supply)));
    endfunction

    function automatic drive_update_t predict_update(drive_cmd_t cmd);
        drive_update_t upd;
        int            t;
        int            cur;
        int            mag;
        int            lim;
        int            supply;
        logic [7:0]    duty;
        t = int'($signed(cmd.target_mv));
        supply = int'(cmd.supply_mv);
        cur = applied_now;
        upd = '0;
        if (t != cur) begin
            mag = (t < 0) ? -t : t;
            if (mag < int'(deadband_cfg)) t = 0;
            if (cur > 0) begin
                if (t > cur && t > cur + int'(slew_up_cfg)) t = cur + int'(slew_up_cfg);
                else if (t < cur && t < cur - int'(slew_down_cfg)) t = cur - int'(slew_down_cfg);
            end else begin
                if (t > cur && t > cur + int'(slew_down_cfg)) t = cur + int'(slew_down_cfg);
                else if (t < cur && t < cur - int'(slew_up_cfg)) t = cur - int'(slew_up_cfg);
            end
        end
        lim = (int'(max_out_cfg) < supply) ? int'(max_out_cfg) : supply;
        if (t > lim) t = lim;
        if (t < -lim) t = -lim;
        duty = duty_for((t < 0) ? -t : t, supply);
        upd.levels.duty = duty;
        if (t != cur) begin
            upd.strobe = 1'b1;
            if (t > 0) upd.levels.level_b = duty;
            if (t < 0) upd.levels.level_a = duty;
            applied_now = t;
            n_strobes++;
        end
        upd.levels.applied_mv = 16'(applied_now);
        n_updates++;
        return upd;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            err_count++;
            $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                s_tdata <= pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: free-running, random, or mostly stalled, switched in stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(10, 80);
                stall_mode = $urandom_range(0, 2);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        drive_update_t want;
        drive_levels_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_updates.push_back(predict_update(drive_cmd_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got = drive_levels_t'(m_tdata);
                if (expected_updates.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected transfer: expected none, got tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_updates.pop_front();
                    check_field("duty", want.levels.duty, got.duty);
                    check_field("write_strobe", want.strobe, m_tuser);
                    check_field("level_a", want.levels.level_a, got.level_a);
                    check_field("level_b", want.levels.level_b, got.level_b);
                    check_field("applied_mv", int'($signed(want.levels.applied_mv)),
                                int'($signed(got.applied_mv)));
                end
            end
        end
    end

    task automatic set_reg(logic [slhb_pkg::CFG_ADDR_W-1:0] idx,
                           logic [slhb_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            slhb_pkg::REG_SLEW_UP:   slew_up_cfg = val;
            slhb_pkg::REG_SLEW_DOWN: slew_down_cfg = val;
            slhb_pkg::REG_DEADBAND:  deadband_cfg = val;
            slhb_pkg::REG_MAX_OUT:   max_out_cfg = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int up, int down, int band, int ceiling);
        set_reg(slhb_pkg::REG_SLEW_UP, slhb_pkg::CFG_W'(up));
        set_reg(slhb_pkg::REG_SLEW_DOWN, slhb_pkg::CFG_W'(down));
        set_reg(slhb_pkg::REG_DEADBAND, slhb_pkg::CFG_W'(band));
        set_reg(slhb_pkg::REG_MAX_OUT, slhb_pkg::CFG_W'(ceiling));
        n_settings++;
    endtask

    task automatic push_cmd(int tgt, int supply);
        drive_cmd_t cmd;
        cmd.target_mv = 16'(tgt);
        cmd.supply_mv = 16'(supply);
        pending_cmds.push_back(cmd);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_updates.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int clip16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int pick_cfg(int lo, int hi);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return CFG_MAX;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic int pick_supply();
        int s;
        case ($urandom_range(0, 19))
            0: return 0;
            1, 2, 3, 4: return $urandom_range(0, 65535);
            5, 6, 7: begin
                s = int'(max_out_cfg) + $urandom_range(0, 4000) - 2000;
                return (s < 0) ? 0 : s;
            end
            default: return $urandom_range(6000, 30000);
        endcase
    endfunction

    task automatic gen_random(int count);
        int made;
        int run_len;
        int tgt;
        int supply;
        int span;
        made = 0;
        tgt = 0;
        while (made < count) begin
            run_len = $urandom_range(1, 40);
            if (run_len > count - made) run_len = count - made;
            supply = pick_supply();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    // hold one target over a run of commands so the output can slew toward it
                    case ($urandom_range(0, 3))
                        0: tgt = int'($signed(16'($urandom)));
                        1: begin
                            span = int'(max_out_cfg) + 2000;
                            tgt = clip16($urandom_range(0, 2 * span) - span);
                        end
                        2: begin
                            span = 2 * int'(deadband_cfg) + 10;
                            tgt = clip16($urandom_range(0, 2 * span) - span);
                        end
                        default: tgt = 0;
                    endcase
                    repeat (run_len) begin
                        if ($urandom_range(0, 4) == 0) supply = pick_supply();
                        push_cmd(tgt, supply);
                        made++;
                    end
                end
                12, 13, 14, 15, 16: begin
                    repeat (run_len) begin
                        tgt = clip16(tgt + $urandom_range(0, 2000) - 1000);
                        push_cmd(tgt, supply);
                        made++;
                    end
                end
                default: begin
                    repeat ((run_len - 1) % 8 + 1) begin
                        pending_cmds.push_back(drive_cmd_t'($urandom));
                        made++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        slew_up_cfg = slhb_pkg::SLEW_UP_RST;
        slew_down_cfg = slhb_pkg::SLEW_DOWN_RST;
        deadband_cfg = slhb_pkg::DEADBAND_RST;
        max_out_cfg = slhb_pkg::MAX_OUT_RST;
        applied_now = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // defaults: no change, rise, deadband, negative full scale, zero supply, crossing
        push_cmd(0, 12000);
        push_cmd(32767, 24000);
        push_cmd(1000, 24000);
        push_cmd(-32768, 24000);
        push_cmd(-5000, 0);
        push_cmd(5000, 12000);
        push_cmd(-5000, 12000);
        gen_random(RANDOM_PER_PHASE);
        wait_drained();

        // widest steps, no deadband, full ceiling
        set_all(CFG_MAX, CFG_MAX, 0, CFG_MAX);
        push_cmd(32767, 65535);
        push_cmd(-32767, 65535);
        push_cmd(-32767, 65535);
        push_cmd(-32767, 65535);
        push_cmd(32767, 1000);
        push_cmd(32767, 1000);
        push_cmd(1, 1);
        push_cmd(-1, 65535);
        push_cmd(128, 65535);
        push_cmd(129, 65535);
        push_cmd(-32768, 65535);
        push_cmd(5000, 5000);
        gen_random(RANDOM_PER_PHASE);
        wait_drained();

        // frozen slew and zero ceiling
        set_all(0, 0, 0, 0);
        push_cmd(100, 5000);
        push_cmd(-100, 0);
        push_cmd(0, 0);
        gen_random(RANDOM_PER_PHASE);
        wait_drained();

        repeat (4) begin
            set_reg(slhb_pkg::CFG_ADDR_W'($urandom_range(slhb_pkg::REG_MAX_OUT + 1, 255)),
                    slhb_pkg::CFG_W'($urandom));
            set_all(pick_cfg(1, 3000), pick_cfg(1, 3000), pick_cfg(0, 4000),
                    pick_cfg(1000, CFG_MAX));
            gen_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        err_count += expected_updates.size();
        $display("Checked %0d drive updates (%0d changed the output) across %0d register settings.",
                 n_updates, n_strobes, n_settings);
        $display("Errors: %0d", err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d updates outstanding",
                 cycle_count, expected_updates.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/slhb_pkg.sv
hw/rtl/slhb_div.sv
hw/rtl/slew_limited_hbridge_drive_top.sv
tb/tb_top.sv
